// ===== rtl/iia_pkg.sv =====
// ----------------------------------------------------------------------------
// iia_pkg
// Shared types and constants for the indexed insert array.
// ----------------------------------------------------------------------------
package iia_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_ELEM_WIDTH = 32;
  localparam int DEF_COUNT_W    = 7;
  localparam int KIND_W         = 2;
  localparam int POS_W          = 8;
  localparam int VALUE_W        = 32;
  localparam int READ_W         = 32;
  localparam int STATUS_W       = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_ASSIGN = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic insert_en;
    logic assign_en;
    logic rd_load;
    logic rd_shift;
  } cell_ctl_t;

endpackage

// ===== rtl/iia_if.sv =====
// ----------------------------------------------------------------------------
// iia_if
// Valid/ready channels for operation and result beats.
// ----------------------------------------------------------------------------
interface iia_in_if import iia_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface iia_out_if import iia_pkg::*; #(
  parameter int COUNT_W = DEF_COUNT_W
) ();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  entry_count;
  logic [READ_W-1:0]   read_value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output entry_count, output read_value, output status,
                  input ready);
  modport sink   (input valid, input entry_count, input read_value, input status,
                  output ready);
endinterface

// ===== rtl/iia_cell.sv =====
// ----------------------------------------------------------------------------
// iia_cell
// One storage slot of the array with its own read shift stage.
// ----------------------------------------------------------------------------
module iia_cell import iia_pkg::*; #(
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
  parameter int IDX_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [IDX_W-1:0]      target,
  input  logic [ELEM_WIDTH-1:0] value,
  input  logic [ELEM_WIDTH-1:0] prev_entry,
  input  logic [ELEM_WIDTH-1:0] rd_in,
  output logic [ELEM_WIDTH-1:0] entry,
  output logic [ELEM_WIDTH-1:0] rd
);

  logic hit;
  logic above;

  assign hit   = (target == IDX_W'(INDEX));
  assign above = (target < IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (ctl.insert_en) begin
      if (above) begin
        entry <= prev_entry;
      end else if (hit) begin
        entry <= value;
      end
    end else if (ctl.assign_en && hit) begin
      entry <= value;
    end
  end

  // read path: selected slot loads, then words walk toward slot zero
  always_ff @(posedge clk) begin
    if (ctl.rd_load) begin
      rd <= hit ? entry : '0;
    end else if (ctl.rd_shift) begin
      rd <= rd_in;
    end
  end

endmodule

// ===== rtl/indexed_insert_array.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_array
// Fixed-capacity ordered word array with insert, append, assign and read.
// ----------------------------------------------------------------------------
// The array is a row of CAPACITY cells, one word each. An insert moves every
// cell above the target up by one neighbor, all in the same cycle; assign loads
// one cell. For insert, append, assign and every rejected operation the result
// is registered at the edge that accepts the beat. A successful read captures
// the selected word into the cell's read stage; it walks down the chain one
// cell per cycle to cell zero and then loads into the result register once free.
// One operation is in flight at a time; the next beat is taken once the read
// walk is done and the result register is free or being emptied.
module indexed_insert_array import iia_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  iia_in_if.sink      cmd,
  iia_out_if.source   rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  state_t                  state;
  state_t                  state_next;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        rd_left;
  logic                    out_valid;
  logic [CNT_W-1:0]        out_count;
  logic [READ_W-1:0]       out_read;
  status_t                 out_status;

  logic                    out_free;
  logic                    acc;
  cell_ctl_t               ctl;
  logic [IDX_W-1:0]        target;
  logic [ELEM_WIDTH-1:0]   elem_in;
  logic                    grow;
  logic                    load_out;
  status_t                 new_status;
  logic [READ_W-1:0]       new_read;
  logic                    start_read;

  logic signed [CMP_W-1:0] pos_s;
  logic signed [CMP_W-1:0] cnt_s;
  logic signed [CMP_W-1:0] ins_pos;
  logic signed [CMP_W-1:0] rd_idx;
  logic signed [CMP_W-1:0] tgt_s;

  logic [ELEM_WIDTH-1:0]   ent [CAPACITY];
  logic [ELEM_WIDTH-1:0]   rdv [CAPACITY];

  assign out_free  = !out_valid || rsp.ready;
  assign cmd.ready = (state == ST_IDLE) && out_free;
  assign acc       = cmd.valid && cmd.ready;
  assign elem_in   = ELEM_WIDTH'(cmd.value);

  assign pos_s   = {{(CMP_W-POS_W){cmd.position[POS_W-1]}}, cmd.position};
  assign cnt_s   = $signed(CMP_W'(count));
  assign ins_pos = (kind_t'(cmd.kind) == KIND_APPEND) ? cnt_s : pos_s;
  assign rd_idx  = (pos_s < 0) ? (pos_s + cnt_s) : pos_s;

  always_comb begin
    state_next = state;
    ctl        = '0;
    tgt_s      = pos_s;
    grow       = 1'b0;
    load_out   = 1'b0;
    start_read = 1'b0;
    new_status = STATUS_OK;
    new_read   = '0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (kind_t'(cmd.kind))
            KIND_INSERT, KIND_APPEND: begin
              tgt_s    = ins_pos;
              load_out = 1'b1;
              if (ins_pos < 0 || ins_pos > cnt_s) begin
                new_status = STATUS_RANGE;
              end else if (count == CNT_W'(CAPACITY)) begin
                new_status = STATUS_FULL;
              end else begin
                ctl.insert_en = 1'b1;
                grow          = 1'b1;
              end
            end
            KIND_ASSIGN: begin
              load_out = 1'b1;
              if (pos_s < 0 || pos_s >= cnt_s) begin
                new_status = STATUS_RANGE;
              end else begin
                ctl.assign_en = 1'b1;
              end
            end
            KIND_READ: begin
              tgt_s = rd_idx;
              if (rd_idx < 0 || rd_idx >= cnt_s) begin
                load_out   = 1'b1;
                new_status = STATUS_RANGE;
              end else begin
                ctl.rd_load = 1'b1;
                start_read  = 1'b1;
                state_next  = ST_READ;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (rd_left != '0) begin
          ctl.rd_shift = 1'b1;
        end else if (out_free) begin
          load_out   = 1'b1;
          new_read   = READ_W'(rdv[0]);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign target = tgt_s[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (grow) begin
        count <= count + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_read) begin
      rd_left <= target;
    end else if (ctl.rd_shift) begin
      rd_left <= rd_left - IDX_W'(1);
    end
    if (load_out) begin
      out_count  <= grow ? (count + CNT_W'(1)) : count;
      out_read   <= new_read;
      out_status <= new_status;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.entry_count = out_count;
  assign rsp.read_value  = out_read;
  assign rsp.status      = out_status;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ELEM_WIDTH-1:0] prev_entry;
    logic [ELEM_WIDTH-1:0] rd_in;
    if (k == 0) begin : g_first
      assign prev_entry = '0;
    end else begin : g_link
      assign prev_entry = ent[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign rd_in = '0;
    end else begin : g_rlink
      assign rd_in = rdv[k+1];
    end
    iia_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (k)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .target     (target),
      .value      (elem_in),
      .prev_entry (prev_entry),
      .rd_in      (rd_in),
      .entry      (ent[k]),
      .rd         (rdv[k])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_grow_step: assert property (@(posedge clk) disable iff (rst)
    grow |=> (count == $past(count) + CNT_W'(1)) && out_valid)
    else $error("insert did not add exactly one entry");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !cmd.ready && !grow)
    else $error("new beat taken during read walk");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_RANGE ||
                   rsp.status == STATUS_FULL))
    else $error("bad status code on result");
`endif

endmodule
